// File: hdl/ssfd_pkg.sv
// Shared types, codes and constants of the serial status frame deframer.
package ssfd_pkg;

  // Frame store geometry.
  localparam int STORE_DEPTH = 20;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  // Frame marks and commands.
  localparam logic [7:0] HEAD_FRAME  = 8'h5A;
  localparam logic [7:0] CMD_CELL    = 8'h05;
  localparam logic [7:0] CMD_DOCK    = 8'h06;
  localparam logic [7:0] DOCK_MARK_A = 8'hAA;
  localparam logic [7:0] DOCK_MARK_B = 8'hBB;
  localparam logic [7:0] HEAD_STATUS = 8'hAB;
  localparam logic [7:0] TAIL_STATUS = 8'hBA;
  localparam logic [7:0] CODE_NONE   = 8'hFF;
  localparam logic [7:0] CODE_START  = 8'h01;
  localparam logic [7:0] CODE_DONE   = 8'h02;

  // Length bytes as carried in the frame, and the store index of the sum byte.
  localparam logic [7:0] LEN_CELL = 8'd20;
  localparam logic [7:0] LEN_DOCK = 8'd11;
  localparam logic [STORE_IDX_W-1:0] CELL_LAST_IDX = STORE_IDX_W'(19);
  localparam logic [STORE_IDX_W-1:0] DOCK_LAST_IDX = STORE_IDX_W'(10);

  // Result kinds.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_CELL = 2'd1;
  localparam logic [1:0] KIND_DOCK = 2'd2;

  // Climber report codes.
  localparam logic [1:0] REPORT_IDLE = 2'd0;
  localparam logic [1:0] REPORT_RUN  = 2'd1;
  localparam logic [1:0] REPORT_DONE = 2'd2;

  // One accepted input item.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] cells_first;
    logic [47:0] cells_second;
    logic [31:0] frame_id;
    logic [7:0]  dock_code;
    logic [1:0]  climber_report;
  } result_t;

  // True for a byte that can open a frame.
  function automatic logic is_head(input logic [7:0] b);
    return (b == HEAD_FRAME) || (b == HEAD_STATUS);
  endfunction

endpackage

// File: hdl/serial_status_frame_deframer.sv
// Top level of the serial status frame deframer: input and result registers.
// The block takes one item per cycle, a received byte or a report tick, and
// gives its result as follows: the item is held in an input register,
// decoded in one pass against a 20-byte frame store, and the result
// lands in an output register. A stalled result holds the input register, so
// accepts continue at one per cycle while out_tready is high. Ticks always give
// a result; bytes give one only when they complete a cell or docking frame
// whose sum and marks check out. There is no clearing pass after reset.
module serial_status_frame_deframer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic [0:0]   in_tuser,   // [0] func
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] cells_first, [95:48] cells_second, [127:96] frame_id,
  // [135:128] dock_code, [137:136] climber_report, [143:138] zero
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser   // [1:0] kind
);
  import ssfd_pkg::*;

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  result_t  out_res_r;
  logic     advance;
  logic     step_en;
  logic     res_valid;
  result_t  res;

  // The input register moves on whenever the result register can take a slot.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step_en   = in_valid_r && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.func    <= in_tuser[0];
      in_item_r.rx_byte <= in_tdata;
    end
  end

  ssfd_frame_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_item (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'd0, out_res_r.climber_report, out_res_r.dock_code,
                       out_res_r.frame_id, out_res_r.cells_second,
                       out_res_r.cells_first};

endmodule

// File: hdl/ssfd_frame_engine.sv
// Frame store, climber state and the single-pass frame decode for one item.
module ssfd_frame_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  ssfd_pkg::in_item_t step_item,
  output logic              res_valid,
  output ssfd_pkg::result_t res
);
  import ssfd_pkg::*;

  logic [7:0]             store_r   [STORE_DEPTH];
  logic [7:0]             store_nxt [STORE_DEPTH];
  logic [STORE_IDX_W-1:0] fill_r, fill_nxt;
  logic [7:0]             sum_r, sum_nxt;
  logic [7:0]             last_code_r, last_code_nxt;
  logic                   active_r, active_nxt;
  logic                   pending_r, pending_nxt;
  logic [7:0]             b;
  logic [7:0]             x;

  assign b = step_item.rx_byte;
  assign x = store_r[1];

  // Decode of one item. Between items the store is empty or holds a frame
  // head that waits for more bytes, so re-examination after a dropped head
  // only ever covers the two bytes behind it.
  always_comb begin
    store_nxt     = store_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    last_code_nxt = last_code_r;
    active_nxt    = active_r;
    pending_nxt   = pending_r;
    res_valid     = 1'b0;
    res           = '0;
    if (step_en) begin
      if (step_item.func) begin
        // Report tick.
        res_valid = 1'b1;
        res.kind  = KIND_TICK;
        if (pending_r) begin
          res.climber_report = REPORT_DONE;
          pending_nxt        = 1'b0;
          active_nxt         = 1'b0;
        end else if (active_r) begin
          res.climber_report = REPORT_RUN;
        end else begin
          res.climber_report = REPORT_IDLE;
        end
      end else if (fill_r == '0) begin
        // Empty store: keep only a frame head.
        if (is_head(b)) begin
          store_nxt[0] = b;
          fill_nxt     = STORE_IDX_W'(1);
          sum_nxt      = b;
        end
      end else if (fill_r == STORE_IDX_W'(1)) begin
        store_nxt[1] = b;
        fill_nxt     = STORE_IDX_W'(2);
        sum_nxt      = sum_r + b;
      end else if (fill_r == STORE_IDX_W'(2)) begin
        // Third byte decides the header.
        if ((store_r[0] == HEAD_FRAME) &&
            (((b == CMD_CELL) && (x == LEN_CELL)) ||
             ((b == CMD_DOCK) && (x == LEN_DOCK)))) begin
          store_nxt[2] = b;
          fill_nxt     = STORE_IDX_W'(3);
          sum_nxt      = sum_r + b;
        end else if ((store_r[0] == HEAD_STATUS) && (b == TAIL_STATUS)) begin
          // Status frame: act only on a new code.
          fill_nxt = '0;
          sum_nxt  = '0;
          if (x != last_code_r) begin
            last_code_nxt = x;
            if (x == CODE_START) begin
              active_nxt  = 1'b1;
              pending_nxt = 1'b0;
            end else if (x == CODE_DONE) begin
              pending_nxt = 1'b1;
            end
          end
        end else if (is_head(x)) begin
          // Head dropped; the next byte opens a frame.
          store_nxt[0] = x;
          store_nxt[1] = b;
          fill_nxt     = STORE_IDX_W'(2);
          sum_nxt      = x + b;
        end else if (is_head(b)) begin
          store_nxt[0] = b;
          fill_nxt     = STORE_IDX_W'(1);
          sum_nxt      = b;
        end else begin
          fill_nxt = '0;
          sum_nxt  = '0;
        end
      end else if (store_r[2] == CMD_CELL) begin
        // Cell frame body; the last byte is the sum of all before it.
        if (fill_r == CELL_LAST_IDX) begin
          fill_nxt = '0;
          sum_nxt  = '0;
          if (sum_r == b) begin
            res_valid        = 1'b1;
            res.kind         = KIND_CELL;
            res.frame_id     = {store_r[6], store_r[5], store_r[4], store_r[3]};
            res.cells_first  = {store_r[12], store_r[11], store_r[10],
                                store_r[9], store_r[8], store_r[7]};
            res.cells_second = {store_r[18], store_r[17], store_r[16],
                                store_r[15], store_r[14], store_r[13]};
          end
        end else begin
          store_nxt[fill_r] = b;
          fill_nxt          = fill_r + STORE_IDX_W'(1);
          sum_nxt           = sum_r + b;
        end
      end else begin
        // Docking frame body.
        if (fill_r == DOCK_LAST_IDX) begin
          fill_nxt = '0;
          sum_nxt  = '0;
          if ((sum_r == b) && (store_r[7] == DOCK_MARK_A) &&
              (store_r[9] == DOCK_MARK_B)) begin
            res_valid     = 1'b1;
            res.kind      = KIND_DOCK;
            res.frame_id  = {store_r[6], store_r[5], store_r[4], store_r[3]};
            res.dock_code = store_r[8];
          end
        end else begin
          store_nxt[fill_r] = b;
          fill_nxt          = fill_r + STORE_IDX_W'(1);
          sum_nxt           = sum_r + b;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      sum_r       <= '0;
      last_code_r <= CODE_NONE;
      active_r    <= 1'b0;
      pending_r   <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      last_code_r <= last_code_nxt;
      active_r    <= active_nxt;
      pending_r   <= pending_nxt;
    end
  end

  // Frame store contents; entries at or beyond the fill count are never read.
  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

// File: hdl/ssfd_checker.sv
// Port-level checker of the serial status frame deframer and its bind.
module ssfd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic [1:0]   out_tuser
);
  import ssfd_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A tick report carries only a legal climber report.
  a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_TICK) |->
      (out_tdata[135:0] == '0) && (out_tdata[137:136] != 2'd3))
    else $error("tick report carries frame fields");

  // A cell result carries no docking code and no climber report.
  a_cell_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CELL) |-> (out_tdata[143:128] == '0))
    else $error("cell result carries docking or report fields");

  // A docking result carries no cells and no climber report.
  a_dock_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DOCK) |->
      (out_tdata[95:0] == '0) && (out_tdata[143:136] == '0))
    else $error("docking result carries cell or report fields");

endmodule

bind serial_status_frame_deframer ssfd_checker u_ssfd_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the serial status frame deframer: stream stimulus, predictor, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfd_pkg::*;

  localparam int CELL_BYTES   = 20;
  localparam int DOCK_BYTES   = 11;
  localparam int STAT_BYTES   = 3;
  localparam int TOTAL_ITEMS  = 1350;
  localparam int CALM_ITEMS   = 120;
  localparam int DRAIN_CYCLES = 20;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;   // [7:0] rx_byte
  logic [0:0]   in_tuser = 1'b0;    // [0] func
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [47:0] cells_first, [95:48] cells_second, [127:96] frame_id,
  // [135:128] dock_code, [137:136] climber_report, [143:138] zero
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;          // [1:0] kind

  serial_status_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Items waiting to be driven, bytes of the frame being built, results still due.
  in_item_t   stim_q[$];
  logic [7:0] frame_bytes[$];
  result_t    expected_results[$];

  int fail_count   = 0;
  int items_sent   = 0;
  int ticks_seen   = 0;
  int cells_seen   = 0;
  int docks_seen   = 0;
  int idle_left    = 0;
  int stall_left   = 0;
  in_item_t drive_item;

  // Predictor state: the deframer's byte buffer, its sum and the climber flags.
  logic [7:0]  frame_buf[STORE_DEPTH];
  int unsigned buf_fill;
  logic [7:0]  buf_sum;
  logic [7:0]  last_code;
  logic        climbing;
  logic        done_pending;

  function automatic void clear_deframer();
    for (int k = 0; k < STORE_DEPTH; k++) frame_buf[k] = 8'h00;
    buf_fill     = 0;
    buf_sum      = 8'h00;
    last_code    = CODE_NONE;
    climbing     = 1'b0;
    done_pending = 1'b0;
  endfunction

  // Remove n bytes from the front of the buffer and take them out of the sum.
  function automatic void buf_drop(int unsigned n);
    int unsigned cnt;
    cnt = (n > buf_fill) ? buf_fill : n;
    for (int unsigned k = 0; k < cnt; k++) buf_sum -= frame_buf[k];
    for (int unsigned k = 0; k + cnt < buf_fill; k++) frame_buf[k] = frame_buf[k + cnt];
    buf_fill -= cnt;
  endfunction

  function automatic logic [47:0] buf_le(int unsigned start, int unsigned count);
    logic [47:0] v;
    v = '0;
    for (int unsigned k = 0; k < count; k++) v |= 48'(frame_buf[start + k]) << (8 * k);
    return v;
  endfunction

  // Look for complete frames at the front of the buffer until it stalls or empties.
  function automatic void scan_frames();
    logic [7:0] s;
    logic [7:0] code;
    bit         got;
    result_t    r;
    got = 1'b0;
    while (buf_fill > 0) begin
      if (frame_buf[0] == HEAD_FRAME) begin
        if (buf_fill < 3) break;
        if (frame_buf[2] == CMD_CELL && frame_buf[1] == LEN_CELL) begin
          if (buf_fill < CELL_BYTES) break;
          s = buf_sum - frame_buf[CELL_BYTES-1];
          if (buf_fill == CELL_BYTES && s == frame_buf[CELL_BYTES-1] && !got) begin
            r = '0;
            r.kind         = KIND_CELL;
            r.cells_first  = buf_le(7, 6);
            r.cells_second = buf_le(13, 6);
            r.frame_id     = 32'(buf_le(3, 4));
            expected_results = {expected_results, r};
            got = 1'b1;
          end
          buf_drop(CELL_BYTES);
        end else if (frame_buf[2] == CMD_DOCK && frame_buf[1] == LEN_DOCK) begin
          if (buf_fill < DOCK_BYTES) break;
          s = 8'h00;
          for (int k = 0; k < DOCK_BYTES - 1; k++) s += frame_buf[k];
          if (s == frame_buf[DOCK_BYTES-1] && frame_buf[7] == DOCK_MARK_A &&
              frame_buf[9] == DOCK_MARK_B && !got) begin
            r = '0;
            r.kind      = KIND_DOCK;
            r.frame_id  = 32'(buf_le(3, 4));
            r.dock_code = frame_buf[8];
            expected_results = {expected_results, r};
            got = 1'b1;
          end
          buf_drop(DOCK_BYTES);
        end else begin
          // Wrong command or length: only the head goes, the rest is looked at again.
          buf_drop(1);
        end
      end else if (frame_buf[0] == HEAD_STATUS) begin
        if (buf_fill < STAT_BYTES) break;
        if (frame_buf[2] == TAIL_STATUS) begin
          code = frame_buf[1];
          if (code != last_code) begin
            last_code = code;
            if (code == CODE_START) begin
              climbing     = 1'b1;
              done_pending = 1'b0;
            end else if (code == CODE_DONE) begin
              done_pending = 1'b1;
            end
          end
          buf_drop(STAT_BYTES);
        end else begin
          buf_drop(1);
        end
      end else begin
        buf_drop(1);
      end
    end
  endfunction

  // Work out what one accepted item causes and queue the result, if any.
  function automatic void predict_item(logic func, logic [7:0] b);
    result_t r;
    if (func) begin
      r = '0;
      r.kind = KIND_TICK;
      if (done_pending) begin
        r.climber_report = REPORT_DONE;
        done_pending     = 1'b0;
        climbing         = 1'b0;
      end else if (climbing) begin
        r.climber_report = REPORT_RUN;
      end else begin
        r.climber_report = REPORT_IDLE;
      end
      expected_results = {expected_results, r};
    end else begin
      if (buf_fill >= STORE_DEPTH) buf_drop(1);
      frame_buf[buf_fill] = b;
      buf_fill++;
      buf_sum += b;
      scan_frames();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Stimulus building.
  function automatic void push_byte(logic [7:0] b);
    in_item_t it;
    it.func    = 1'b0;
    it.rx_byte = b;
    stim_q = {stim_q, it};
  endfunction

  function automatic void push_tick(logic [7:0] filler);
    in_item_t it;
    it.func    = 1'b1;
    it.rx_byte = filler;
    stim_q = {stim_q, it};
  endfunction

  function automatic void add_le(logic [47:0] v, int count);
    for (int k = 0; k < count; k++) frame_bytes = {frame_bytes, v[8*k +: 8]};
  endfunction

  function automatic void seal_sum();
    logic [7:0] s;
    s = 8'h00;
    foreach (frame_bytes[k]) s += frame_bytes[k];
    frame_bytes = {frame_bytes, s};
  endfunction

  function automatic void make_cell(logic [31:0] id, logic [47:0] lo, logic [47:0] hi);
    frame_bytes = {HEAD_FRAME, LEN_CELL, CMD_CELL};
    add_le(48'(id), 4);
    add_le(lo, 6);
    add_le(hi, 6);
    seal_sum();
  endfunction

  function automatic void make_dock(logic [31:0] id, logic [7:0] code);
    frame_bytes = {HEAD_FRAME, LEN_DOCK, CMD_DOCK};
    add_le(48'(id), 4);
    frame_bytes = {frame_bytes, DOCK_MARK_A, code, DOCK_MARK_B};
    seal_sum();
  endfunction

  function automatic void make_status(logic [7:0] code);
    frame_bytes = {HEAD_STATUS, code, TAIL_STATUS};
  endfunction

  // Queue the built frame, now and then with report ticks between its bytes.
  function automatic void send_frame_bytes(bit with_ticks);
    foreach (frame_bytes[k]) begin
      if (with_ticks && $urandom_range(0, 5) == 0) push_tick(8'($urandom));
      push_byte(frame_bytes[k]);
    end
  endfunction

  // Driver: offers the next queued item once the current one is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) begin
          predict_item(in_tuser[0], in_tdata);
          items_sent++;
        end
        if (idle_left == 0 && stim_q.size() >= CALM_ITEMS && $urandom_range(0, 11) == 0)
          idle_left = $urandom_range(1, 11);
        if (idle_left > 0 || stim_q.size() == 0) begin
          if (idle_left > 0) idle_left--;
          in_tvalid <= 1'b0;
        end else begin
          drive_item = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drive_item.func;
          in_tdata  <= drive_item.rx_byte;
        end
      end
    end
  end

  // Monitor: checks each taken result against the oldest one due, stalls at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting: kind 0x%0h, data 0x%0h",
                 out_tuser, out_tdata);
          fail_count++;
        end else begin
          check_field("kind", 64'(expected_results[0].kind), 64'(out_tuser));
          check_field("cells_first", 64'(expected_results[0].cells_first),
                      64'(out_tdata[47:0]));
          check_field("cells_second", 64'(expected_results[0].cells_second),
                      64'(out_tdata[95:48]));
          check_field("frame_id", 64'(expected_results[0].frame_id),
                      64'(out_tdata[127:96]));
          check_field("dock_code", 64'(expected_results[0].dock_code),
                      64'(out_tdata[135:128]));
          check_field("climber_report", 64'(expected_results[0].climber_report),
                      64'(out_tdata[137:136]));
          case (expected_results[0].kind)
            KIND_TICK: ticks_seen++;
            KIND_CELL: cells_seen++;
            default:   docks_seen++;
          endcase
          void'(expected_results.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stim_q.size() >= CALM_ITEMS && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int pick;
    int roll;
    int directed_count;
    logic [7:0] code;

    clear_deframer();

    // Report before any status, then a start and a repeated start.
    push_tick(8'hFF);
    make_status(CODE_START);
    send_frame_bytes(1'b0);
    push_tick(8'h00);
    make_status(CODE_START);
    send_frame_bytes(1'b0);
    push_tick(8'hA5);

    // Cell frames at the extremes of id and cell values, and one with mixed values.
    make_cell(32'h0000_0000, 48'h0, 48'h0);
    send_frame_bytes(1'b0);
    make_cell(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_frame_bytes(1'b0);
    make_cell(32'h1234_5678, 48'h0605_0403_0201, 48'h0C0B_0A09_0807);
    send_frame_bytes(1'b0);

    // Docking frames with the extremes of the status byte.
    make_dock(32'h8765_4321, 8'h00);
    send_frame_bytes(1'b0);
    make_dock(32'hFFFF_FFFF, 8'hFF);
    send_frame_bytes(1'b0);

    // Unknown head bytes are dropped at once.
    push_byte(8'h00);
    push_byte(8'hFF);

    // Frame head with a wrong length: the bytes after it are looked at again,
    // so the done status that follows still counts.
    push_byte(HEAD_FRAME);
    push_byte(8'h07);
    make_status(CODE_DONE);
    send_frame_bytes(1'b0);
    push_tick(8'h3C);
    push_tick(8'hC3);

    // Length of a cell frame with the docking command.
    push_byte(HEAD_FRAME);
    push_byte(LEN_CELL);
    push_byte(CMD_DOCK);

    // Status frame with a wrong tail, then a good start.
    push_byte(HEAD_STATUS);
    push_byte(CODE_START);
    make_status(CODE_START);
    send_frame_bytes(1'b0);
    push_tick(8'h5A);

    // Cell frame with a failed sum.
    make_cell(32'hDEAD_BEEF, 48'h1111_2222_3333, 48'h4444_5555_6666);
    frame_bytes[CELL_BYTES-1] ^= 8'h01;
    send_frame_bytes(1'b0);

    // Docking frames without the first or the second mark, sums made good.
    make_dock(32'h0102_0304, 8'h42);
    void'(frame_bytes.pop_back());
    frame_bytes[7] = 8'hA9;
    seal_sum();
    send_frame_bytes(1'b0);
    make_dock(32'h0506_0708, 8'h24);
    void'(frame_bytes.pop_back());
    frame_bytes[9] = 8'hBC;
    seal_sum();
    send_frame_bytes(1'b0);

    // A stray head in front of a good docking frame.
    push_byte(HEAD_FRAME);
    make_dock(32'hCAFE_F00D, 8'h81);
    send_frame_bytes(1'b0);

    // A code that is only remembered, then done, reported once.
    make_status(8'h07);
    send_frame_bytes(1'b0);
    make_status(CODE_DONE);
    send_frame_bytes(1'b0);
    push_tick(8'h01);
    push_tick(8'h80);
    directed_count = stim_q.size();

    // Random part: mostly well-formed frames with random content, some broken.
    while (stim_q.size() < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        make_cell($urandom, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end else if (pick < 46) begin
        make_dock($urandom, 8'($urandom));
      end else if (pick < 64) begin
        roll = $urandom_range(0, 9);
        if (roll < 4)      code = CODE_START;
        else if (roll < 7) code = CODE_DONE;
        else if (roll < 8) code = CODE_NONE;
        else               code = 8'($urandom);
        make_status(code);
      end else if (pick < 80) begin
        push_tick(8'($urandom));
        continue;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          roll = $urandom_range(0, 3);
          if (roll == 0)      push_byte(HEAD_FRAME);
          else if (roll == 1) push_byte(HEAD_STATUS);
          else                push_byte(8'($urandom));
        end
        continue;
      end
      // Damage some frames: one byte flipped, or the tail cut off.
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
      end else if (roll < 18) begin
        repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
      end
      send_frame_bytes($urandom_range(0, 9) == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d items, %0d of them directed; checked %0d reports,", items_sent,
             directed_count, ticks_seen);
    $display("%0d cell frames and %0d docking frames.", cells_seen, docks_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
